/* design/qdp_pkg.sv */
// qdp_pkg: shared types, codes and default sizes for the per-device queue depth
// tracker. No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package qdp_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned TableEntries = 64;
  localparam int unsigned CountBits    = 16;

  // Fixed field widths
  localparam int unsigned MajorW = 12;
  localparam int unsigned MinorW = 20;
  localparam int unsigned KeyW   = MajorW + MinorW;
  localparam int unsigned DepthW = 16;
  localparam int unsigned PeakW  = 15;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_KEY = 2'd1,
    ST_FULL     = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  typedef enum logic {
    OP_ISSUE    = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  typedef logic [KeyW-1:0] key_t;

  // Outcome of the key lookup, passed from the match stage to the count stage
  typedef struct packed {
    status_e status;
    logic    fresh;   // entry claimed by this request, counts start at zero
  } lookup_t;

endpackage

/* design/per_device_queue_depth_peak.sv */
// per_device_queue_depth_peak: top level, request/result handshakes and stage
// control. Depends on qdp_pkg, qdp_match and qdp_count.
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  in      | request   | in_valid_i / in_ready_o | operation_i, major_number_i, minor_number_i
//  out     | result    | out_valid_o / out_ready_i | status_o, current_depth_o, peak_seen_o
//
//  One request per cycle sustained while out_ready_i is high; a request passes the
//  input register, then the memory read register, then the result register.
//  The depth/peak memory's read is registered, and a write to the
//  entry being read is forwarded, so back-to-back requests to one device work.
//  Reset empties the table at once through the fill counter; no clearing pass.
//  With out_ready_i low the stages fill up and in_ready_o drops after three.

module per_device_queue_depth_peak #(
  parameter int unsigned TABLE_ENTRIES = qdp_pkg::TableEntries,
  parameter int unsigned COUNT_BITS    = qdp_pkg::CountBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [qdp_pkg::MajorW-1:0]          major_number_i,
  input  logic [qdp_pkg::MinorW-1:0]          minor_number_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [qdp_pkg::DepthW-1:0]   current_depth_o,
  output logic [qdp_pkg::PeakW-1:0]           peak_seen_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);

  logic                              a_valid_q;
  logic                              b_valid_q;
  logic                              out_valid_q;
  qdp_pkg::op_e                      a_op_q;
  qdp_pkg::key_t                     a_key_q;
  logic                              a_adv;
  logic                              b_adv;
  logic                              in_fire;
  qdp_pkg::lookup_t                  look;
  logic [IdxW-1:0]                   look_idx;
  qdp_pkg::status_e                  b_status;
  logic signed [qdp_pkg::DepthW-1:0] b_depth;
  logic [qdp_pkg::PeakW-1:0]         b_peak;
  qdp_pkg::status_e                  out_status_q;
  logic signed [qdp_pkg::DepthW-1:0] out_depth_q;
  logic [qdp_pkg::PeakW-1:0]         out_peak_q;

  // Stage flow control
  assign b_adv      = b_valid_q && (!out_valid_q || out_ready_i);
  assign a_adv      = a_valid_q && (!b_valid_q || b_adv);
  assign in_ready_o = !a_valid_q || a_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (!b_valid_q || b_adv) begin
        b_valid_q <= a_valid_q;
      end
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_op_q  <= qdp_pkg::op_e'(operation_i);
      a_key_q <= {major_number_i, minor_number_i};
    end
  end

  qdp_match #(
    .TableEntries (TABLE_ENTRIES)
  ) u_match (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (a_adv),
    .op_i      (a_op_q),
    .key_i     (a_key_q),
    .look_o    (look),
    .idx_o     (look_idx)
  );

  qdp_count #(
    .TableEntries (TABLE_ENTRIES),
    .CountBits    (COUNT_BITS)
  ) u_count (
    .clk_i    (clk_i),
    .load_i   (a_adv),
    .commit_i (b_adv),
    .op_i     (a_op_q),
    .look_i   (look),
    .idx_i    (look_idx),
    .status_o (b_status),
    .depth_o  (b_depth),
    .peak_o   (b_peak)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_status_q <= b_status;
      out_depth_q  <= b_depth;
      out_peak_q   <= b_peak;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign current_depth_o = out_depth_q;
  assign peak_seen_o     = out_peak_q;

  // Checks
  a_reject_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != qdp_pkg::ST_OK) |-> (current_depth_o == '0) && (peak_seen_o == '0))
    else $error("non-ok result carries counts");

  a_zero_key_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && (a_key_q == '0) |-> (look.status == qdp_pkg::ST_ZERO_KEY) && !look.fresh)
    else $error("zero key not ignored");

  a_stage_b_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !b_adv |=> b_valid_q && $stable(b_status))
    else $error("count stage lost a stalled request");

  a_peak_covers_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == qdp_pkg::ST_OK) && (COUNT_BITS <= 16)
      |-> current_depth_o <= signed'({1'b0, peak_seen_o}))
    else $error("depth above peak");

endmodule

/* design/qdp_match.sv */
// qdp_match: key table with parallel compare and fill counter for entry claims.
// Depends on qdp_pkg.
`timescale 1ns / 1ps

module qdp_match #(
  parameter int unsigned TableEntries = qdp_pkg::TableEntries,
  localparam int unsigned IdxW  = $clog2(TableEntries),
  localparam int unsigned FillW = $clog2(TableEntries + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  qdp_pkg::op_e        op_i,
  input  qdp_pkg::key_t       key_i,
  output qdp_pkg::lookup_t    look_o,
  output logic [IdxW-1:0]     idx_o
);

  // Entries are claimed lowest first and never released, so the valid
  // entries are always 0 .. fill_q-1.
  qdp_pkg::key_t          key_q [TableEntries];
  logic [FillW-1:0]       fill_q;
  logic [TableEntries-1:0] hit;
  logic [IdxW-1:0]        hit_idx;
  logic                   any_hit;
  logic                   full;
  logic                   zero_key;
  logic                   claim;

  // Parallel compare against every valid key; keys are unique, so OR-encode
  always_comb begin
    hit_idx = '0;
    for (int unsigned i = 0; i < TableEntries; i++) begin
      hit[i] = (FillW'(i) < fill_q) && (key_q[i] == key_i);
      if (hit[i]) begin
        hit_idx = hit_idx | IdxW'(i);
      end
    end
  end

  assign any_hit  = |hit;
  assign full     = (fill_q == FillW'(TableEntries));
  assign zero_key = (key_i == '0);

  // Status of the request and the entry it works on
  always_comb begin
    look_o.fresh = 1'b0;
    idx_o        = hit_idx;
    if (zero_key) begin
      look_o.status = qdp_pkg::ST_ZERO_KEY;
    end else if (any_hit) begin
      look_o.status = qdp_pkg::ST_OK;
    end else if (op_i == qdp_pkg::OP_COMPLETE) begin
      look_o.status = qdp_pkg::ST_UNKNOWN;
    end else if (full) begin
      look_o.status = qdp_pkg::ST_FULL;
    end else begin
      look_o.status = qdp_pkg::ST_OK;
      look_o.fresh  = 1'b1;
      idx_o         = fill_q[IdxW-1:0];
    end
  end

  assign claim = advance_i && look_o.fresh;

  // Fill counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (claim) begin
      fill_q <= fill_q + FillW'(1);
    end
  end

  // Key store, written once per claimed entry
  always_ff @(posedge clk_i) begin
    if (claim) begin
      key_q[fill_q[IdxW-1:0]] <= key_i;
    end
  end

endmodule

/* design/qdp_count.sv */
// qdp_count: depth/peak memory with registered read, count update and
// write-to-read forwarding. Depends on qdp_pkg.
`timescale 1ns / 1ps

module qdp_count #(
  parameter int unsigned TableEntries = qdp_pkg::TableEntries,
  parameter int unsigned CountBits    = qdp_pkg::CountBits,
  localparam int unsigned IdxW = $clog2(TableEntries)
) (
  input  logic                                clk_i,
  input  logic                                load_i,    // request moves into this stage
  input  logic                                commit_i,  // request leaves this stage
  input  qdp_pkg::op_e                        op_i,
  input  qdp_pkg::lookup_t                    look_i,
  input  logic [IdxW-1:0]                     idx_i,
  output qdp_pkg::status_e                    status_o,
  output logic signed [qdp_pkg::DepthW-1:0]   depth_o,
  output logic [qdp_pkg::PeakW-1:0]           peak_o
);

  localparam int unsigned WordW = 2 * CountBits;
  localparam logic signed [CountBits-1:0] CntMax = {1'b0, {(CountBits-1){1'b1}}};
  localparam logic signed [CountBits-1:0] CntMin = {1'b1, {(CountBits-1){1'b0}}};

  // Word layout: {peak, depth}
  logic [WordW-1:0]            mem [TableEntries];
  logic [WordW-1:0]            rd_q;
  logic [WordW-1:0]            fwd_word_q;
  logic [WordW-1:0]            base_word;
  logic [WordW-1:0]            wr_word;
  logic                        fwd_q;
  qdp_pkg::op_e                op_q;
  qdp_pkg::lookup_t            look_q;
  logic [IdxW-1:0]             idx_q;
  logic signed [CountBits-1:0] base_cnt;
  logic signed [CountBits-1:0] new_cnt;
  logic [CountBits-1:0]        base_peak;
  logic [CountBits-1:0]        new_peak;
  logic                        wr_en;
  logic signed [63:0]          cnt_wide;
  logic [63:0]                 peak_wide;

  // Old counts: zero for a fresh entry, else the write that landed on the
  // same entry at the read edge, else the memory
  always_comb begin
    if (look_q.fresh) begin
      base_word = '0;
    end else if (fwd_q) begin
      base_word = fwd_word_q;
    end else begin
      base_word = rd_q;
    end
  end

  assign base_cnt  = signed'(base_word[CountBits-1:0]);
  assign base_peak = base_word[WordW-1:CountBits];

  // Saturating step and peak update (peak stays non-negative)
  always_comb begin
    new_peak = base_peak;
    if (op_q == qdp_pkg::OP_ISSUE) begin
      new_cnt = (base_cnt != CntMax) ? base_cnt + CountBits'(1) : base_cnt;
      if (new_cnt > signed'(base_peak)) begin
        new_peak = unsigned'(new_cnt);
      end
    end else begin
      new_cnt = (base_cnt != CntMin) ? base_cnt - CountBits'(1) : base_cnt;
    end
  end

  assign wr_word = {new_peak, unsigned'(new_cnt)};
  assign wr_en   = commit_i && (look_q.status == qdp_pkg::ST_OK);

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= wr_word;
    end
    if (load_i) begin
      rd_q <= mem[idx_i];
    end
  end

  // Stage payload and forwarding capture
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      op_q       <= op_i;
      look_q     <= look_i;
      idx_q      <= idx_i;
      fwd_q      <= wr_en && (idx_q == idx_i);
      fwd_word_q <= wr_word;
    end
  end

  // Result fields: low bits of depth (sign-extended) and peak
  assign cnt_wide  = 64'(new_cnt);
  assign peak_wide = 64'(new_peak);

  always_comb begin
    status_o = look_q.status;
    if (look_q.status == qdp_pkg::ST_OK) begin
      depth_o = signed'(cnt_wide[qdp_pkg::DepthW-1:0]);
      peak_o  = peak_wide[qdp_pkg::PeakW-1:0];
    end else begin
      depth_o = '0;
      peak_o  = '0;
    end
  end

endmodule
